// ===== hw/rtl/zmtp_greeting_handshake_macros.svh =====
// ----------------------------------------------------------------------------
// Greeting handshake assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ZMTP_GREETING_HANDSHAKE_MACROS_SVH
`define ZMTP_GREETING_HANDSHAKE_MACROS_SVH

// property must hold at every edge outside reset
`define ZGH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition must never be seen outside reset
`define ZGH_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/zgh_pkg.sv =====
// ----------------------------------------------------------------------------
// Greeting handshake package
// Types, codes and byte tables shared by the front and back parts.
// ----------------------------------------------------------------------------
package zgh_pkg;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_RX    = 1'b1;

   localparam logic [2:0] OUT_PENDING = 3'd0;
   localparam logic [2:0] OUT_V1_NOID = 3'd1;
   localparam logic [2:0] OUT_V1_ID   = 3'd2;
   localparam logic [2:0] OUT_V2      = 3'd3;
   localparam logic [2:0] OUT_V3_NULL = 3'd4;

   localparam logic [7:0] BYTE_SIG_HEAD = 8'hff;
   localparam logic [7:0] BYTE_SIG_TAIL = 8'h7f;
   localparam logic [7:0] BYTE_MAJOR    = 8'h03;
   localparam logic [7:0] BYTE_MINOR    = 8'h00;
   localparam logic [7:0] BYTE_N        = 8'h4e;
   localparam logic [7:0] BYTE_U        = 8'h55;
   localparam logic [7:0] BYTE_L        = 8'h4c;

   localparam logic [6:0] RX_SIG_BODY = 7'd9;   // bytes up to the flags byte
   localparam logic [6:0] RX_SIG_DONE = 7'd10;
   localparam logic [6:0] RX_VER_DONE = 7'd11;
   localparam logic [6:0] RX_V2_DONE  = 7'd12;
   localparam logic [6:0] RX_V3_DONE  = 7'd64;

   localparam logic [5:0] LEN_SIG  = 6'd10;
   localparam logic [5:0] LEN_V3   = 6'd53;
   localparam logic [5:0] LEN_ONE  = 6'd1;

   typedef enum logic [5:0] {
      PH_FIRST = 6'b000001,
      PH_SIG   = 6'b000010,
      PH_VER   = 6'b000100,
      PH_V2    = 6'b001000,
      PH_V3    = 6'b010000,
      PH_DONE  = 6'b100000
   } phase_type;

   typedef enum logic [2:0] {
      JOB_STATUS = 3'd0,   // no byte to send, one status result
      JOB_SIG    = 3'd1,   // own 10-byte signature
      JOB_MAJOR  = 3'd2,   // major version byte
      JOB_MINOR  = 3'd3,   // minor byte, v2 greeting
      JOB_V3     = 3'd4    // 53-byte greeting remainder, NULL mechanism
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [8:0]   sig_value;   // own id length + 1
      logic         done;
      logic [2:0]   outcome;
      logic [63:0]  peer_ident_len;
      logic         error;
   } job_type;

   function automatic logic [5:0] job_len(job_kind_type kind);
      logic [5:0] len;
      case (kind)
         JOB_SIG: len = LEN_SIG;
         JOB_V3:  len = LEN_V3;
         default: len = LEN_ONE;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] job_byte(job_kind_type kind, logic [5:0] idx,
                                          logic [8:0] sig_value);
      logic [7:0] b;
      b = 8'h00;
      case (kind)
         JOB_SIG: begin
            if (idx == 6'd0) begin
               b = BYTE_SIG_HEAD;
            end else if (idx == 6'd7) begin
               b = {7'd0, sig_value[8]};
            end else if (idx == 6'd8) begin
               b = sig_value[7:0];
            end else if (idx == 6'd9) begin
               b = BYTE_SIG_TAIL;
            end
         end
         JOB_MAJOR: b = BYTE_MAJOR;
         JOB_MINOR: b = BYTE_MINOR;
         JOB_V3: begin
            if (idx == 6'd1) begin
               b = BYTE_N;
            end else if (idx == 6'd2) begin
               b = BYTE_U;
            end else if (idx == 6'd3 || idx == 6'd4) begin
               b = BYTE_L;
            end
         end
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== hw/rtl/zgh_front.sv =====
// ----------------------------------------------------------------------------
// Greeting handshake front part
// Parses peer bytes one per transfer and posts one job per item.
// ----------------------------------------------------------------------------
`include "zmtp_greeting_handshake_macros.svh"

module zgh_front
   import zgh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       cmd,
   input  logic [7:0] rx_byte,
   input  logic [7:0] own_id_length,
   output job_type    job
);

   phase_type   phase_ff, phase_in;
   logic [6:0]  rx_count_ff, rx_count_in;
   logic [63:0] peer_length_ff, peer_length_in;
   logic [2:0]  outcome_ff, outcome_in;
   job_kind_type kind;
   logic        err;

   always_comb begin
      phase_in       = phase_ff;
      rx_count_in    = rx_count_ff;
      peer_length_in = peer_length_ff;
      outcome_in     = outcome_ff;
      kind           = JOB_STATUS;
      err            = 1'b0;
      if (cmd == CMD_START) begin
         kind = JOB_SIG;
      end else begin
         case (phase_ff)
            PH_FIRST: begin
               if (rx_byte != BYTE_SIG_HEAD) begin
                  // old peer: this byte is its identity length
                  peer_length_in = {56'd0, rx_byte};
                  phase_in       = PH_DONE;
                  outcome_in     = (rx_byte == 8'd0) ? OUT_V1_NOID : OUT_V1_ID;
               end else begin
                  rx_count_in = 7'd1;
                  phase_in    = PH_SIG;
               end
            end
            PH_SIG: begin
               if (rx_count_ff < RX_SIG_BODY) begin
                  peer_length_in = {peer_length_ff[55:0], rx_byte};
                  rx_count_in    = rx_count_ff + 7'd1;
               end else begin
                  rx_count_in = RX_SIG_DONE;
                  if (rx_byte[0]) begin
                     kind     = JOB_MAJOR;
                     phase_in = PH_VER;
                  end else begin
                     phase_in   = PH_DONE;
                     outcome_in = (peer_length_ff == 64'd0) ? OUT_V1_NOID : OUT_V1_ID;
                  end
               end
            end
            PH_VER: begin
               rx_count_in = RX_VER_DONE;
               if (rx_byte == 8'd0 || rx_byte == 8'd1) begin
                  kind     = JOB_MINOR;
                  phase_in = PH_V2;
               end else begin
                  kind     = JOB_V3;
                  phase_in = PH_V3;
               end
            end
            PH_V2: begin
               rx_count_in = RX_V2_DONE;
               phase_in    = PH_DONE;
               outcome_in  = OUT_V2;
            end
            PH_V3: begin
               if (rx_count_ff >= RX_V3_DONE - 7'd1) begin
                  rx_count_in = RX_V3_DONE;
                  phase_in    = PH_DONE;
                  outcome_in  = OUT_V3_NULL;
               end else begin
                  rx_count_in = rx_count_ff + 7'd1;
               end
            end
            default: err = 1'b1;   // byte after done
         endcase
      end
   end

   always_comb begin
      job.kind           = kind;
      job.sig_value      = {1'b0, own_id_length} + 9'd1;
      job.done           = (phase_in == PH_DONE);
      job.outcome        = outcome_in;
      job.peer_ident_len = (outcome_in == OUT_V1_ID) ? peer_length_in - 64'd1 : 64'd0;
      job.error          = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_FIRST;
         rx_count_ff    <= 7'd0;
         peer_length_ff <= 64'd0;
         outcome_ff     <= OUT_PENDING;
      end else if (accept) begin
         phase_ff       <= phase_in;
         rx_count_ff    <= rx_count_in;
         peer_length_ff <= peer_length_in;
         outcome_ff     <= outcome_in;
      end
   end

   `ZGH_ASSERT(a_done_sticky, phase_ff == PH_DONE |=> phase_ff == PH_DONE, "done phase left")
   `ZGH_ASSERT(a_outcome_done, (phase_ff == PH_DONE) == (outcome_ff != OUT_PENDING), "outcome/phase mismatch")

endmodule

// ===== hw/rtl/zgh_job_queue.sv =====
// ----------------------------------------------------------------------------
// Greeting handshake job queue
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
module zgh_job_queue
   import zgh_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    full,
   output logic    empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   job_type        entry_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]  count_ff;
   logic           do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

// ===== hw/rtl/zgh_back.sv =====
// ----------------------------------------------------------------------------
// Greeting handshake back part
// Expands queued jobs into results, one per cycle while rsp_pop takes them, into an output register.
// ----------------------------------------------------------------------------
module zgh_back
   import zgh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  job_type     head_job,
   input  logic        head_empty,
   output logic        head_pop,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last,
   output logic        rsp_done_res,
   output logic [2:0]  rsp_outcome,
   output logic [63:0] rsp_peer_ident_len,
   output logic        rsp_error
);

   logic [5:0]  idx_ff, idx_in;
   logic        out_valid_ff, out_valid_in;
   logic        tx_valid_ff;
   logic [7:0]  tx_byte_ff;
   logic        last_ff;
   logic        done_ff;
   logic [2:0]  outcome_ff;
   logic [63:0] pid_ff;
   logic        error_ff;
   logic        advance, emit, is_last;

   assign advance  = !out_valid_ff || rsp_pop;
   assign emit     = advance && !head_empty;
   assign is_last  = (idx_ff == job_len(head_job.kind) - 6'd1);
   assign head_pop = emit && is_last;

   always_comb begin
      idx_in = idx_ff;
      if (emit) begin
         idx_in = is_last ? 6'd0 : idx_ff + 6'd1;
      end
      out_valid_in = emit ? 1'b1 : (advance ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 6'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         tx_valid_ff <= (head_job.kind != JOB_STATUS);
         tx_byte_ff  <= job_byte(head_job.kind, idx_ff, head_job.sig_value);
         last_ff     <= is_last;
         done_ff     <= head_job.done;
         outcome_ff  <= head_job.outcome;
         pid_ff      <= head_job.peer_ident_len;
         error_ff    <= head_job.error;
      end
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_tx_valid       = tx_valid_ff;
   assign rsp_tx_byte        = tx_byte_ff;
   assign rsp_last           = last_ff;
   assign rsp_done_res       = done_ff;
   assign rsp_outcome        = outcome_ff;
   assign rsp_peer_ident_len = pid_ff;
   assign rsp_error          = error_ff;

endmodule

// ===== hw/rtl/zmtp_greeting_handshake.sv =====
// Path: an accepted item's job is written into the job queue; the back part then registers
// its result into the output register, which drives the rsp_ ports.
// Throughput: one item per cycle in while the queue has room; one result per cycle out while
// rsp_pop takes them. The back part's byte counter gives a start item 10 results, the v3 greeting item 53, others 1.
// Reset: synchronous, active high; parser returns to awaiting the first signature byte,
// queue and output register empty, own_id_length cleared to 0.
// ----------------------------------------------------------------------------
// Greeting handshake with version fallback
// Front parser posts jobs into a short queue; back part turns each job into
// its burst of transmit bytes or a single status result.
// ----------------------------------------------------------------------------
`include "zmtp_greeting_handshake_macros.svh"

module zmtp_greeting_handshake
   import zgh_pkg::*;
#(
   parameter int JOB_DEPTH = 4
)
(
   input  logic        clock,
   input  logic        reset,
   // input queue side
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_cmd,
   input  logic [7:0]  req_rx_byte,
   // result queue side
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last,
   output logic        rsp_done_res,
   output logic [2:0]  rsp_outcome,
   output logic [63:0] rsp_peer_ident_len,
   output logic        rsp_error,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_own_id_length
);

   logic [7:0] own_id_length_ff;
   logic       req_accept;
   job_type    front_job;
   job_type    head_job;
   logic       q_full, q_empty, q_pop;

   // config register: always ready, one transfer per cycle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_length_ff <= 8'd0;
      end else if (csr_valid && csr_ready) begin
         own_id_length_ff <= csr_own_id_length;
      end
   end

   // an item is taken whenever the job queue has room; every item makes one job
   assign req_full   = q_full;
   assign req_accept = req_push && !q_full;

   zgh_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .cmd           (req_cmd),
      .rx_byte       (req_rx_byte),
      .own_id_length (own_id_length_ff),
      .job           (front_job)
   );

   zgh_job_queue #(
      .DEPTH (JOB_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_accept),
      .push_job (front_job),
      .pop      (q_pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   // back part drains the queue head, one result per cycle while rsp side takes them
   zgh_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_job           (head_job),
      .head_empty         (q_empty),
      .head_pop           (q_pop),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_tx_valid       (rsp_tx_valid),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_last           (rsp_last),
      .rsp_done_res       (rsp_done_res),
      .rsp_outcome        (rsp_outcome),
      .rsp_peer_ident_len (rsp_peer_ident_len),
      .rsp_error          (rsp_error)
   );

   // status-only results are always the single, final result of their item
   `ZGH_ASSERT(a_status_last, !rsp_empty && !rsp_tx_valid |-> rsp_last && rsp_tx_byte == 8'd0, "status result not last")
   // late bytes are only flagged once the handshake is finished
   `ZGH_ASSERT_NEVER(a_error_done, !rsp_empty && rsp_error && !rsp_done_res, "error before done")
   // queue must never be popped while it is empty
   `ZGH_ASSERT_NEVER(a_pop_empty, q_pop && q_empty, "job pop from empty queue")

endmodule

// ===== sim/zmtp_greeting_handshake_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greeting handshake regression bench
// Pushes start commands and peer greeting bytes through the block, predicts
// every transmit byte and status result, and checks them on the result side.
// ----------------------------------------------------------------------------
module zmtp_greeting_handshake_test;
   import zgh_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   // one input item as the driver presents it
   typedef struct {
      logic       cmd;
      logic [7:0] rx_byte;
   } peer_item_type;

   // one result transfer as the monitor expects it
   typedef struct {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        last;
      logic        done;
      logic [2:0]  outcome;
      logic [63:0] peer_ident_len;
      logic        error;
   } greet_word_type;

   logic        clock;
   logic        reset;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_cmd = CMD_START;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_last;
   logic        rsp_done_res;
   logic [2:0]  rsp_outcome;
   logic [63:0] rsp_peer_ident_len;
   logic        rsp_error;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_own_id_length = 8'h00;

   // items waiting for the driver, results waiting for the monitor
   peer_item_type  peer_items[$];
   greet_word_type greet_expect[$];

   // handshake state as the bench sees it
   phase_type   hs_phase;
   logic [6:0]  hs_rx_count;
   logic [63:0] hs_peer_len;
   logic [2:0]  hs_outcome;
   logic [7:0]  own_len;

   int          mismatches = 0;
   int          cycles = 0;
   bit          calm = 1'b0;   // no idling on either side while set

   zmtp_greeting_handshake DUT (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_cmd            (req_cmd),
      .req_rx_byte        (req_rx_byte),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_tx_valid       (rsp_tx_valid),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_last           (rsp_last),
      .rsp_done_res       (rsp_done_res),
      .rsp_outcome        (rsp_outcome),
      .rsp_peer_ident_len (rsp_peer_ident_len),
      .rsp_error          (rsp_error),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_own_id_length  (csr_own_id_length)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // a break with a chance of 7 in 100, none during a calm phase
   function automatic bit take_break();
      return !calm && ($urandom_range(0, 99) < 7);
   endfunction

   // Advance the handshake by one accepted item and queue the results it
   // causes. A start emits the 10-byte signature and leaves the state alone;
   // anything that sends no byte still yields one status result.
   task automatic predict_greeting(input logic cmd, input logic [7:0] b);
      logic [7:0]     burst[$];
      logic [63:0]    sig;
      logic           err;
      greet_word_type w;
      int             n;
      err = 1'b0;
      if (cmd == CMD_START) begin
         sig = {56'd0, own_len} + 64'd1;
         burst.push_back(BYTE_SIG_HEAD);
         for (int i = 7; i >= 0; i--)
            burst.push_back(sig[8*i +: 8]);
         burst.push_back(BYTE_SIG_TAIL);
      end else begin
         case (hs_phase)
            PH_FIRST: begin
               if (b != BYTE_SIG_HEAD) begin
                  // old-style peer: this byte is the identity length
                  hs_peer_len = {56'd0, b};
                  hs_phase    = PH_DONE;
                  hs_outcome  = (hs_peer_len == 64'd0) ? OUT_V1_NOID : OUT_V1_ID;
               end else begin
                  hs_rx_count = 7'd1;
                  hs_phase    = PH_SIG;
               end
            end
            PH_SIG: begin
               if (hs_rx_count < RX_SIG_BODY) begin
                  hs_peer_len = {hs_peer_len[55:0], b};
                  hs_rx_count = hs_rx_count + 7'd1;
               end else begin
                  // flags byte: bit 0 set means a versioned peer
                  hs_rx_count = RX_SIG_DONE;
                  if (b[0]) begin
                     burst.push_back(BYTE_MAJOR);
                     hs_phase = PH_VER;
                  end else begin
                     hs_phase   = PH_DONE;
                     hs_outcome = (hs_peer_len == 64'd0) ? OUT_V1_NOID : OUT_V1_ID;
                  end
               end
            end
            PH_VER: begin
               hs_rx_count = RX_VER_DONE;
               burst.push_back(BYTE_MINOR);
               if (b <= 8'd1) begin
                  hs_phase = PH_V2;
               end else begin
                  // rest of the v3 greeting: mechanism name, then zero padding
                  burst.push_back(BYTE_N);
                  burst.push_back(BYTE_U);
                  burst.push_back(BYTE_L);
                  burst.push_back(BYTE_L);
                  repeat (48) burst.push_back(8'h00);
                  hs_phase = PH_V3;
               end
            end
            PH_V2: begin
               hs_rx_count = RX_V2_DONE;
               hs_phase    = PH_DONE;
               hs_outcome  = OUT_V2;
            end
            PH_V3: begin
               hs_rx_count = hs_rx_count + 7'd1;
               if (hs_rx_count >= RX_V3_DONE) begin
                  hs_rx_count = RX_V3_DONE;
                  hs_phase    = PH_DONE;
                  hs_outcome  = OUT_V3_NULL;
               end
            end
            default: err = 1'b1;   // peer byte after the handshake finished
         endcase
      end

      n = (burst.size() == 0) ? 1 : burst.size();
      for (int i = 0; i < n; i++) begin
         w.tx_valid       = (burst.size() != 0);
         w.tx_byte        = (burst.size() != 0) ? burst[i] : 8'h00;
         w.last           = (i == n - 1);
         w.done           = (hs_phase == PH_DONE);
         w.outcome        = hs_outcome;
         w.peer_ident_len = (hs_outcome == OUT_V1_ID && hs_peer_len != 64'd0) ?
                            hs_peer_len - 64'd1 : 64'd0;
         w.error          = err;
         greet_expect.push_back(w);
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] exp_val,
                              input logic [63:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
         mismatches++;
      end
   endtask

   // Driver: a slot opens when nothing is presented or the last one was
   // taken; push is assigned once per edge so a held item never glitches.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full)
            predict_greeting(req_cmd, req_rx_byte);
         if (!req_push || !req_full) begin
            if (peer_items.size() != 0 && !take_break()) begin
               req_cmd     <= peer_items[0].cmd;
               req_rx_byte <= peer_items[0].rx_byte;
               req_push    <= 1'b1;
               void'(peer_items.pop_front());
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Monitor: pop stalls at random; every result transfer is compared
   // field by field with the oldest expectation.
   always @(posedge clock) begin
      greet_word_type w;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (greet_expect.size() == 0) begin
               $display("%0t: unexpected result, expected none, got byte %0h last %0b",
                        $time, rsp_tx_byte, rsp_last);
               mismatches++;
            end else begin
               w = greet_expect.pop_front();
               check_field("tx_valid", w.tx_valid, rsp_tx_valid);
               check_field("tx_byte", w.tx_byte, rsp_tx_byte);
               check_field("last", w.last, rsp_last);
               check_field("done_res", w.done, rsp_done_res);
               check_field("outcome", w.outcome, rsp_outcome);
               check_field("peer_ident_len", w.peer_ident_len, rsp_peer_ident_len);
               check_field("error", w.error, rsp_error);
            end
         end
         rsp_pop <= !take_break();
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("zmtp_greeting_handshake regression: fail");
         $finish;
      end
   end

   task automatic add_start();
      peer_item_type it;
      it.cmd     = CMD_START;
      it.rx_byte = 8'($urandom);   // ignored by the block, toggled anyway
      peer_items.push_back(it);
   endtask

   // peer byte, now and then preceded by a start mid-handshake
   task automatic add_peer_byte(input logic [7:0] b);
      peer_item_type it;
      if ($urandom_range(0, 7) == 0)
         add_start();
      it.cmd     = CMD_RX;
      it.rx_byte = b;
      peer_items.push_back(it);
   endtask

   // register writes only happen with the block drained
   task automatic write_own_len(input logic [7:0] v);
      @(posedge clock);
      csr_valid         <= 1'b1;
      csr_own_id_length <= v;
      do @(posedge clock); while (!csr_ready);
      own_len   = v;
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (peer_items.size() != 0 || req_push || greet_expect.size() != 0);
      repeat (4) @(posedge clock);   // margin after the last result
   endtask

   // One full peer greeting on a path picked at random. Only one handshake
   // fits in a run, since done is sticky until reset.
   task automatic add_handshake();
      int          path;
      int          len_mode;
      logic [7:0]  b;
      path = $urandom_range(0, 4);
      if (path == 0) begin
         // old-style peer, identity length in the first byte
         b = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 254));
         add_peer_byte(b);
      end else begin
         add_peer_byte(BYTE_SIG_HEAD);
         len_mode = $urandom_range(0, 3);
         repeat (8) begin
            case (len_mode)
               0:       b = 8'h00;
               1:       b = 8'hff;
               default: b = 8'($urandom);
            endcase
            add_peer_byte(b);
         end
         b = 8'($urandom);
         if (path == 1) begin
            add_peer_byte(b & 8'hfe);   // no version: length-prefixed old peer
         end else begin
            add_peer_byte(b | 8'h01);
            if (path == 2) begin
               add_peer_byte(8'($urandom_range(0, 1)));   // v2 peer
               add_peer_byte(8'($urandom));
            end else begin
               add_peer_byte(8'($urandom_range(2, 255)));   // v3 peer
               repeat (53) add_peer_byte(8'($urandom));
            end
         end
      end
   endtask

   initial begin
      logic [7:0] cfg;
      reset       = 1'b1;
      hs_phase    = PH_FIRST;
      hs_rx_count = 7'd0;
      hs_peer_len = 64'd0;
      hs_outcome  = OUT_PENDING;
      own_len     = 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset config, a signature, then the peer greeting
      add_start();
      add_handshake();
      add_start();
      wait_drained();

      // directed: extremes of the length register, bytes after done
      write_own_len(8'hff);
      add_start();
      add_peer_byte(8'h00);
      add_peer_byte(8'hff);
      add_start();
      wait_drained();
      write_own_len(8'h00);
      add_start();
      add_peer_byte(8'h55);
      add_peer_byte(8'haa);
      wait_drained();

      // random phases: new length each time, mixed starts and late bytes
      for (int k = 0; k < 6; k++) begin
         case (k)
            0:       cfg = 8'h01;
            1:       cfg = 8'h80;
            default: cfg = 8'($urandom);
         endcase
         write_own_len(cfg);
         calm = (k == 2);
         repeat (50) begin
            if ($urandom_range(0, 99) < 35)
               add_start();
            else
               add_peer_byte(8'($urandom));
         end
         wait_drained();
      end
      calm = 1'b0;

      repeat (10) @(posedge clock);
      if (mismatches == 0 && greet_expect.size() == 0)
         $display("zmtp_greeting_handshake regression: pass");
      else
         $display("zmtp_greeting_handshake regression: fail");
      $finish;
   end

endmodule
